// ===== design/gdut_pkg.sv =====
package gdut_pkg;

  // Field widths
  localparam int SAMPLE_W   = 13;
  localparam int TIME_W     = 32;
  localparam int VAL_W      = 32;
  localparam int THR_W      = 8;
  localparam int INTERVAL_W = 16;
  localparam int CFG_W      = 16;
  localparam int IN_W       = 48;
  localparam int OUT_W      = 96;

  // Register reset values
  localparam logic [THR_W-1:0]      THRESHOLD_RESET = 8'd3;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET  = 16'd250;

  // Angles in tenths of a degree
  localparam logic signed [VAL_W-1:0] FULL_TURN = 32'sd3600;
  localparam logic signed [VAL_W-1:0] HALF_TURN = 32'sd1800;

  // Register indexes
  typedef enum logic {
    REG_THRESHOLD = 1'b0,
    REG_INTERVAL  = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [THR_W-1:0]      threshold;
    logic [INTERVAL_W-1:0] interval;
  } cfg_t;

  // Clamp a 34-bit signed sum to the 32-bit signed range
  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [VAL_W+1:0] v);
    logic signed [VAL_W-1:0] r;
    if (v > 34'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -34'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = $signed(v[VAL_W-1:0]);
    end
    return r;
  endfunction

endpackage

// ===== design/gdut_drift.sv =====
module gdut_drift (
  input  logic                                clk,
  input  logic                                rst,
  input  gdut_pkg::cfg_t                      cfg,
  input  logic                                load,
  input  logic signed [gdut_pkg::SAMPLE_W-1:0] sample,
  input  logic [gdut_pkg::TIME_W-1:0]         now_ms,
  output logic signed [gdut_pkg::VAL_W-1:0]   drift_sum
);

  logic signed [gdut_pkg::SAMPLE_W-1:0] ref_sample;
  logic [gdut_pkg::TIME_W-1:0]          last_check;

  logic [gdut_pkg::TIME_W-1:0]          elapsed;
  logic                                 check_due;
  logic signed [gdut_pkg::SAMPLE_W:0]   diff;
  logic [gdut_pkg::SAMPLE_W:0]          mag;
  logic                                 below;
  logic signed [gdut_pkg::VAL_W-1:0]    drift_sum_next;

  // Elapsed time wraps modulo 2^32
  assign elapsed   = now_ms - last_check;
  assign check_due = elapsed > {{(gdut_pkg::TIME_W-gdut_pkg::INTERVAL_W){1'b0}}, cfg.interval};

  // Sample change since the last check and its magnitude
  assign diff  = $signed({sample[gdut_pkg::SAMPLE_W-1], sample})
               - $signed({ref_sample[gdut_pkg::SAMPLE_W-1], ref_sample});
  assign mag   = diff[gdut_pkg::SAMPLE_W] ? 14'(-diff) : 14'(diff);
  assign below = mag < {{(gdut_pkg::SAMPLE_W+1-gdut_pkg::THR_W){1'b0}}, cfg.threshold};

  // Fold the change into the correction, clamped
  assign drift_sum_next = gdut_pkg::sat32(
      $signed({{2{drift_sum[gdut_pkg::VAL_W-1]}}, drift_sum})
    - $signed({{(gdut_pkg::VAL_W+1-gdut_pkg::SAMPLE_W){diff[gdut_pkg::SAMPLE_W]}}, diff}));

  // Update the reference at each due check, and the correction when the change is below threshold
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_sample <= '0;
      last_check <= '0;
      drift_sum  <= '0;
    end else if (load && check_due) begin
      ref_sample <= sample;
      last_check <= now_ms;
      if (below) begin
        drift_sum <= drift_sum_next;
      end
    end
  end

endmodule

// ===== design/gyro_drift_unwrap_tracker.sv =====
// Channel    Direction  Contents (low bit up)
// s_axis     in         tdata: sample[12:0], now_ms[44:13], zero pad to 48
// m_axis     out        tdata: heading[31:0], absolute_heading[63:32],
//                       drift_correction[95:64]
// cfg        in         write only: cfg_we, cfg_index, cfg_data
//
// Five register stages: input, drift update, corrected heading, folded
// change, heading total. One request per cycle unless a stalled output
// backs up to the input. Each stage's state lives in that stage.
// Synchronous reset clears state and valid bits, config returns to 3/250.
// Each stage advances when it is empty or the next one advances, so a
// stalled output still fills the bubbles behind it.
module gyro_drift_unwrap_tracker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [gdut_pkg::IN_W-1:0]    s_axis_tdata,  // sample, now_ms
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [gdut_pkg::OUT_W-1:0]   m_axis_tdata,  // heading, absolute_heading, drift_correction
  input  logic                         cfg_we,
  input  logic [0:0]                   cfg_index,
  input  logic [gdut_pkg::CFG_W-1:0]   cfg_data
);

  localparam int VW = gdut_pkg::VAL_W;
  localparam int SW = gdut_pkg::SAMPLE_W;

  gdut_pkg::cfg_t cfg;

  logic v0, v1, v2, v3, v4;
  logic en0, en1, en2, en3, en4;

  logic signed [SW-1:0]           s0_sample;
  logic [gdut_pkg::TIME_W-1:0]    s0_now;
  logic signed [SW-1:0]           s1_sample;
  logic signed [VW-1:0]           drift_sum;
  logic signed [VW-1:0]           h2, d2;
  logic signed [VW-1:0]           h3, d3;
  logic signed [VW:0]             delta3;
  logic signed [VW-1:0]           h4, d4;
  logic signed [VW-1:0]           prev_heading;
  logic signed [VW-1:0]           heading_total;

  logic signed [VW+1:0]           sum2;
  logic signed [VW-1:0]           hs2;
  logic signed [VW-1:0]           h2_next;
  logic signed [VW:0]             delta;
  logic signed [VW:0]             delta_next;
  logic signed [VW-1:0]           total_next;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold <= gdut_pkg::THRESHOLD_RESET;
      cfg.interval  <= gdut_pkg::INTERVAL_RESET;
    end else if (cfg_we) begin
      unique case (gdut_pkg::reg_index_t'(cfg_index))
        gdut_pkg::REG_THRESHOLD: cfg.threshold <= cfg_data[gdut_pkg::THR_W-1:0];
        gdut_pkg::REG_INTERVAL:  cfg.interval  <= cfg_data[gdut_pkg::INTERVAL_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage advance chain
  assign en4 = !v4 || m_axis_tready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign en0 = !v0 || en1;
  assign s_axis_tready = en0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en0) v0 <= s_axis_tvalid;
      if (en1) v1 <= v0;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  // Stage 0: capture the request
  always_ff @(posedge clk) begin
    if (en0 && s_axis_tvalid) begin
      s0_sample <= $signed(s_axis_tdata[SW-1:0]);
      s0_now    <= s_axis_tdata[SW+gdut_pkg::TIME_W-1:SW];
    end
  end

  // Stage 1: drift check and correction
  gdut_drift u_drift (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .load      (en1 && v0),
    .sample    (s0_sample),
    .now_ms    (s0_now),
    .drift_sum (drift_sum)
  );

  always_ff @(posedge clk) begin
    if (en1 && v0) begin
      s1_sample <= s0_sample;
    end
  end

  // Stage 2: corrected heading, clamped, negative folded once
  assign sum2    = $signed({{(VW+2-SW){s1_sample[SW-1]}}, s1_sample})
                 + $signed({{2{drift_sum[VW-1]}}, drift_sum});
  assign hs2     = gdut_pkg::sat32(sum2);
  assign h2_next = hs2[VW-1] ? hs2 + gdut_pkg::FULL_TURN : hs2;

  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      h2 <= h2_next;
      d2 <= drift_sum;
    end
  end

  // Stage 3: change from the previous heading, folded once
  assign delta = $signed({h2[VW-1], h2}) - $signed({prev_heading[VW-1], prev_heading});

  always_comb begin
    if (delta > $signed({gdut_pkg::HALF_TURN[VW-1], gdut_pkg::HALF_TURN})) begin
      delta_next = delta - $signed({gdut_pkg::FULL_TURN[VW-1], gdut_pkg::FULL_TURN});
    end else if (delta < -$signed({gdut_pkg::HALF_TURN[VW-1], gdut_pkg::HALF_TURN})) begin
      delta_next = delta + $signed({gdut_pkg::FULL_TURN[VW-1], gdut_pkg::FULL_TURN});
    end else begin
      delta_next = delta;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_heading <= '0;
    end else if (en3 && v2) begin
      prev_heading <= h2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && v2) begin
      h3     <= h2;
      d3     <= d2;
      delta3 <= delta_next;
    end
  end

  // Stage 4: accumulate the absolute heading, clamped
  assign total_next = gdut_pkg::sat32($signed({{2{heading_total[VW-1]}}, heading_total})
                                    + $signed({delta3[VW], delta3}));

  always_ff @(posedge clk) begin
    if (rst) begin
      heading_total <= '0;
    end else if (en4 && v3) begin
      heading_total <= total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en4 && v3) begin
      h4 <= h3;
      d4 <= d3;
    end
  end

  assign m_axis_tvalid = v4;
  assign m_axis_tdata  = {d4, heading_total, h4};

  // Folded heading never sits within one full turn of the negative limit
  a_heading_fold: assert property (@(posedge clk) disable iff (rst)
    v4 |-> !(h4[VW-1] && h4 < (32'sh8000_0000 + gdut_pkg::FULL_TURN)))
    else $error("heading below the folded range");

  // Full pipeline with a stalled output takes no request
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (v0 && v1 && v2 && v3 && v4 && !m_axis_tready) |-> !s_axis_tready)
    else $error("request accepted into a full pipeline");

  // Drift correction moves only when stage 1 loads
  a_drift_hold: assert property (@(posedge clk) disable iff (rst)
    !(en1 && v0) |=> $stable(drift_sum))
    else $error("drift correction changed without a request");

  // Absolute heading moves only when the output stage loads
  a_total_hold: assert property (@(posedge clk) disable iff (rst)
    !(en4 && v3) |=> $stable(heading_total))
    else $error("absolute heading changed without a request");

endmodule
